// File: src/world_to_screen_projection_defines.svh
// Assertion macros used by the checker file wsp_checker.sv.
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define WSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled in reset.
`define WSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: src/wsp_pkg.sv
`default_nettype none
package wsp_pkg;

    // Fixed-point format of coordinates and coefficients
    localparam int FRAC_BITS = 16;
    localparam int SIZE_W    = 13;
    localparam int PROD_W    = 64;
    // Clip components: three 64-bit products summed, shifted, plus a coefficient
    localparam int CLIP_W    = 67 - FRAC_BITS;
    // Dividend: magnitude times screen size, scaled by the fraction bits
    localparam int NUM_W     = CLIP_W + SIZE_W + FRAC_BITS;
    // Quotient bits produced by the divider
    localparam int QUOT_W    = 41;
    localparam logic [QUOT_W-1:0] QUOT_CAP = QUOT_W'(1) << (QUOT_W - 1);
    // Smallest clip w times ten that counts as visible
    localparam int VIS_MIN   = 1 << FRAC_BITS;

    // Operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd1080;

    typedef struct packed {
        logic signed [CLIP_W-1:0] cx;
        logic signed [CLIP_W-1:0] cy;
        logic signed [CLIP_W-1:0] cw;
    } clip_t;

    typedef struct packed {
        logic              vis;
        logic              negx;
        logic              negy;
        logic              ovfx;
        logic              ovfy;
        logic [CLIP_W-1:0] den;
        logic [CLIP_W-1:0] remx;
        logic [CLIP_W-1:0] remy;
        logic [QUOT_W-1:0] lowx;
        logic [QUOT_W-1:0] lowy;
        logic [QUOT_W-1:0] qx;
        logic [QUOT_W-1:0] qy;
    } div_t;

endpackage
`default_nettype wire

// File: src/wsp_if.sv
`default_nettype none
interface wsp_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (output valid, operation, coef_index, coef_value, pos_x, pos_y, pos_z,
                    input ready);
    modport sink   (input valid, operation, coef_index, coef_value, pos_x, pos_y, pos_z,
                    output ready);
endinterface

interface wsp_out_if;
    logic               valid;
    logic               ready;
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;

    modport source (output valid, visible, screen_x, screen_y, input ready);
    modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface
`default_nettype wire

// File: src/world_to_screen_projection.sv
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    operation, coef_index, coef_value, pos_x, pos_y, pos_z
// out_ch    out  valid/ready    visible, screen_x, screen_y
// cfg       in   cfg_we         cfg_index, cfg_data (screen_width, screen_height)
//
// One transaction per cycle is accepted while in_ch.ready is high; a project
// transaction passes through 2 multiply/sum stages, 3 prep stages, 41 divider stages
// (one quotient bit per stage) and the output register before its result appears.
// Load transactions update the matrix at acceptance and yield no result.
// rst_n clears the matrix to zeros and sets the screen size to 1920 x 1080.
// A stall on out_ch backs up only occupied stages; empty slots keep accepting.
`default_nettype none
module world_to_screen_projection (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    wsp_in_if.sink                              in_ch,
    wsp_out_if.source                           out_ch,
    input  wire logic                           cfg_we,
    input  wire logic [wsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wsp_pkg::SIZE_W-1:0]     cfg_data
);
    import wsp_pkg::*;

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic              clip_valid, clip_ready;
    clip_t             clip;
    logic              prep_valid, prep_ready;
    div_t              prep;
    logic              div_valid, div_ready;
    div_t              quot;
    logic              out_v_reg;
    logic              vis_reg;
    logic signed [31:0] x_reg, y_reg;
    logic signed [31:0] x_next, y_next;

    // Saturate the signed pixel term to 32 bits
    function automatic logic signed [31:0] to_pixel(logic [QUOT_W-1:0] q, logic ovf,
                                                    logic flip, logic [SIZE_W-1:0] size);
        logic [QUOT_W-1:0]          qm;
        logic signed [QUOT_W+1:0]   v;
        qm = ovf ? QUOT_CAP : q;
        v  = signed'({2'b00, qm});
        if (flip)
            v = -v;
        v = v + (QUOT_W+2)'({size, {(FRAC_BITS-1){1'b0}}});
        if (!v[QUOT_W+1] && v[QUOT_W:31] != '0)
            return 32'sh7fffffff;
        else if (v[QUOT_W+1] && v[QUOT_W:31] != '1)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    wsp_clip u_clip (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .clip_valid (clip_valid),
        .clip_ready (clip_ready),
        .clip       (clip)
    );

    wsp_prep u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .clip_valid    (clip_valid),
        .clip_ready    (clip_ready),
        .clip          (clip),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .prep_valid    (prep_valid),
        .prep_ready    (prep_ready),
        .prep          (prep)
    );

    wsp_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .prep_valid (prep_valid),
        .prep_ready (prep_ready),
        .prep       (prep),
        .div_valid  (div_valid),
        .div_ready  (div_ready),
        .quot       (quot)
    );

    // Map quotients to pixels; y is inverted
    assign x_next = quot.vis ? to_pixel(quot.qx, quot.ovfx, quot.negx, width_reg) : '0;
    assign y_next = quot.vis ? to_pixel(quot.qy, quot.ovfy, !quot.negy, height_reg) : '0;

    assign div_ready = !out_v_reg || out_ch.ready;

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (div_ready)
            out_v_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (div_ready)
        begin
            vis_reg <= quot.vis;
            x_reg   <= x_next;
            y_reg   <= y_next;
        end
    end

    assign out_ch.valid    = out_v_reg;
    assign out_ch.visible  = vis_reg;
    assign out_ch.screen_x = x_reg;
    assign out_ch.screen_y = y_reg;
endmodule
`default_nettype wire

// File: src/wsp_clip.sv
`default_nettype none
module wsp_clip (
    input  wire logic          clk,
    input  wire logic          rst_n,
    wsp_in_if.sink             in_ch,
    output logic               clip_valid,
    input  wire logic          clip_ready,
    output wsp_pkg::clip_t     clip
);
    import wsp_pkg::*;

    logic signed [31:0]       mat_reg [16];
    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [PROD_W-1:0] prod_reg [9];
    logic signed [PROD_W-1:0] prod_next [9];
    logic signed [31:0]       m3_reg [3];
    clip_t                    clip_reg;
    clip_t                    clip_next;
    logic                     en1;
    logic                     en2;
    logic                     accept;

    assign en2         = !v2_reg || clip_ready;
    assign en1         = !v1_reg || en2;
    assign in_ch.ready = en1;
    assign accept      = in_ch.valid && en1;

    // Write a coefficient on a load transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                mat_reg[i] <= '0;
        end
        else if (accept && in_ch.operation == OP_LOAD)
        begin
            mat_reg[in_ch.coef_index] <= in_ch.coef_value;
        end
    end

    // Form the nine products of rows 0, 1 and 3 at acceptance
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            prod_next[l*3+0] = PROD_W'(mat_reg[(l == 2 ? 3 : l)*4+0]) * PROD_W'(in_ch.pos_x);
            prod_next[l*3+1] = PROD_W'(mat_reg[(l == 2 ? 3 : l)*4+1]) * PROD_W'(in_ch.pos_y);
            prod_next[l*3+2] = PROD_W'(mat_reg[(l == 2 ? 3 : l)*4+2]) * PROD_W'(in_ch.pos_z);
        end
    end

    // Sum products, floor to the fixed-point scale, add the fourth column
    always_comb
    begin
        logic signed [PROD_W+1:0] s0;
        logic signed [PROD_W+1:0] s1;
        logic signed [PROD_W+1:0] s3;
        s0 = (PROD_W+2)'(prod_reg[0]) + (PROD_W+2)'(prod_reg[1]) + (PROD_W+2)'(prod_reg[2]);
        s1 = (PROD_W+2)'(prod_reg[3]) + (PROD_W+2)'(prod_reg[4]) + (PROD_W+2)'(prod_reg[5]);
        s3 = (PROD_W+2)'(prod_reg[6]) + (PROD_W+2)'(prod_reg[7]) + (PROD_W+2)'(prod_reg[8]);
        clip_next.cx = CLIP_W'(s0 >>> FRAC_BITS) + CLIP_W'(m3_reg[0]);
        clip_next.cy = CLIP_W'(s1 >>> FRAC_BITS) + CLIP_W'(m3_reg[1]);
        clip_next.cw = CLIP_W'(s3 >>> FRAC_BITS) + CLIP_W'(m3_reg[2]);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= accept && in_ch.operation == OP_PROJECT;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            prod_reg <= prod_next;
            m3_reg[0] <= mat_reg[3];
            m3_reg[1] <= mat_reg[7];
            m3_reg[2] <= mat_reg[15];
        end
        if (en2)
            clip_reg <= clip_next;
    end

    assign clip_valid = v2_reg;
    assign clip       = clip_reg;
endmodule
`default_nettype wire

// File: src/wsp_prep.sv
`default_nettype none
module wsp_prep (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        clip_valid,
    output logic                             clip_ready,
    input  wire wsp_pkg::clip_t              clip,
    input  wire logic [wsp_pkg::SIZE_W-1:0]  screen_width,
    input  wire logic [wsp_pkg::SIZE_W-1:0]  screen_height,
    output logic                             prep_valid,
    input  wire logic                        prep_ready,
    output wsp_pkg::div_t                    prep
);
    import wsp_pkg::*;

    logic              va_reg, vb_reg, vc_reg;
    logic              ena, enb, enc;
    // Stage A: visibility, signs, magnitudes, doubled w as denominator
    logic              visa_reg, negxa_reg, negya_reg;
    logic [CLIP_W-1:0] magx_reg, magy_reg, dena_reg;
    logic              vis_next;
    // Stage B: scaled dividends
    logic              visb_reg, negxb_reg, negyb_reg;
    logic [CLIP_W-1:0] denb_reg;
    logic [NUM_W-1:0]  numx_reg, numy_reg;
    logic [CLIP_W+SIZE_W-1:0] pxn_next, pyn_next;
    // Stage C: overflow test and first partial remainder
    div_t              prep_reg;
    div_t              prep_next;

    assign enc        = !vc_reg || prep_ready;
    assign enb        = !vb_reg || enc;
    assign ena        = !va_reg || enb;
    assign clip_ready = ena;

    // Test clip w against 0.1: w >= 0 and 10 * w >= one
    always_comb
    begin
        logic signed [CLIP_W+3:0] w10;
        w10 = ((CLIP_W+4)'(clip.cw) <<< 3) + ((CLIP_W+4)'(clip.cw) <<< 1);
        vis_next = !clip.cw[CLIP_W-1] && (w10 >= (CLIP_W+4)'(VIS_MIN));
    end

    assign pxn_next = (CLIP_W+SIZE_W)'(magx_reg) * (CLIP_W+SIZE_W)'(screen_width);
    assign pyn_next = (CLIP_W+SIZE_W)'(magy_reg) * (CLIP_W+SIZE_W)'(screen_height);

    always_comb
    begin
        prep_next.vis  = visb_reg;
        prep_next.negx = negxb_reg;
        prep_next.negy = negyb_reg;
        prep_next.den  = denb_reg;
        prep_next.ovfx = CLIP_W'(numx_reg[NUM_W-1:QUOT_W]) >= denb_reg;
        prep_next.ovfy = CLIP_W'(numy_reg[NUM_W-1:QUOT_W]) >= denb_reg;
        prep_next.remx = CLIP_W'(numx_reg[NUM_W-1:QUOT_W]);
        prep_next.remy = CLIP_W'(numy_reg[NUM_W-1:QUOT_W]);
        prep_next.lowx = numx_reg[QUOT_W-1:0];
        prep_next.lowy = numy_reg[QUOT_W-1:0];
        prep_next.qx   = '0;
        prep_next.qy   = '0;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (ena)
                va_reg <= clip_valid;
            if (enb)
                vb_reg <= va_reg;
            if (enc)
                vc_reg <= vb_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (ena)
        begin
            visa_reg  <= vis_next;
            negxa_reg <= clip.cx[CLIP_W-1];
            negya_reg <= clip.cy[CLIP_W-1];
            magx_reg  <= clip.cx[CLIP_W-1] ? CLIP_W'(-clip.cx) : CLIP_W'(clip.cx);
            magy_reg  <= clip.cy[CLIP_W-1] ? CLIP_W'(-clip.cy) : CLIP_W'(clip.cy);
            dena_reg  <= {clip.cw[CLIP_W-2:0], 1'b0};
        end
        if (enb)
        begin
            visb_reg  <= visa_reg;
            negxb_reg <= negxa_reg;
            negyb_reg <= negya_reg;
            denb_reg  <= dena_reg;
            numx_reg  <= {pxn_next, {FRAC_BITS{1'b0}}};
            numy_reg  <= {pyn_next, {FRAC_BITS{1'b0}}};
        end
        if (enc)
            prep_reg <= prep_next;
    end

    assign prep_valid = vc_reg;
    assign prep       = prep_reg;
endmodule
`default_nettype wire

// File: src/wsp_div.sv
`default_nettype none
module wsp_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           prep_valid,
    output logic                prep_ready,
    input  wire wsp_pkg::div_t  prep,
    output logic                div_valid,
    input  wire logic           div_ready,
    output wsp_pkg::div_t       quot
);
    import wsp_pkg::*;

    logic v_reg  [QUOT_W];
    logic en     [QUOT_W];
    div_t st_reg [QUOT_W];
    div_t st_next [QUOT_W];

    // One restoring quotient bit for both lanes
    function automatic div_t div_step(div_t s);
        logic [CLIP_W:0] tx;
        logic [CLIP_W:0] ty;
        div_t            r;
        r  = s;
        tx = {s.remx, s.lowx[QUOT_W-1]};
        ty = {s.remy, s.lowy[QUOT_W-1]};
        if (tx >= {1'b0, s.den})
        begin
            r.remx = CLIP_W'(tx - {1'b0, s.den});
            r.qx   = {s.qx[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            r.remx = tx[CLIP_W-1:0];
            r.qx   = {s.qx[QUOT_W-2:0], 1'b0};
        end
        if (ty >= {1'b0, s.den})
        begin
            r.remy = CLIP_W'(ty - {1'b0, s.den});
            r.qy   = {s.qy[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            r.remy = ty[CLIP_W-1:0];
            r.qy   = {s.qy[QUOT_W-2:0], 1'b0};
        end
        r.lowx = {s.lowx[QUOT_W-2:0], 1'b0};
        r.lowy = {s.lowy[QUOT_W-2:0], 1'b0};
        return r;
    endfunction

    // Stall propagates back only through occupied stages
    always_comb
    begin
        en[QUOT_W-1] = !v_reg[QUOT_W-1] || div_ready;
        for (int k = QUOT_W - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end
    assign prep_ready = en[0];

    always_comb
    begin
        st_next[0] = div_step(prep);
        for (int k = 1; k < QUOT_W; k++)
            st_next[k] = div_step(st_reg[k-1]);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QUOT_W; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= prep_valid;
            for (int k = 1; k < QUOT_W; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QUOT_W; k++)
            if (en[k])
                st_reg[k] <= st_next[k];
    end

    assign div_valid = v_reg[QUOT_W-1];
    assign quot      = st_reg[QUOT_W-1];
endmodule
`default_nettype wire

// File: src/wsp_checker.sv
`default_nettype none
`include "world_to_screen_projection_defines.svh"
module wsp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        visible,
    input wire logic [31:0] screen_x,
    input wire logic [31:0] screen_y
);
    // A waiting result stays offered
    `WSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // A waiting result keeps its payload
    `WSP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(screen_x) && $stable(screen_y) && $stable(visible))
    // A point behind the near limit reports zero coordinates
    `WSP_ASSERT_IMPLY(a_hidden_zero, clk, rst_n, out_valid && !visible, screen_x == 32'd0 && screen_y == 32'd0)
    // An empty output register never blocks the input
    `WSP_ASSERT_IMPLY(a_empty_ready, clk, rst_n, !out_valid, in_ready)
endmodule

bind world_to_screen_projection wsp_checker u_wsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .visible   (out_ch.visible),
    .screen_x  (out_ch.screen_x),
    .screen_y  (out_ch.screen_y)
);
`default_nettype wire

// File: tb/sv/world_to_screen_projection_test.sv
`timescale 1ns / 100ps
`default_nettype none
module world_to_screen_projection_test;
    import wsp_pkg::*;

    typedef struct {
        logic               operation;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } point_cmd_t;

    typedef struct {
        logic               visible;
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
    } pixel_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0] cfg_data;

    wsp_in_if  in_ch ();
    wsp_out_if out_ch ();

    world_to_screen_projection DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the block state
    logic signed [31:0] coef_shadow [16];
    logic [SIZE_W-1:0]  width_shadow;
    logic [SIZE_W-1:0]  height_shadow;

    point_cmd_t cmd_queue [$];
    pixel_t     pixel_queue [$];

    int errors;
    int loads_done;
    int projects_done;
    int pixels_checked;
    int visible_checked;
    int burst_left;
    int gap_left;
    int stall_pct;
    int stall_timer;

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Clip component for one matrix row, floored to the fraction bits
    function automatic logic signed [95:0] clip_row(input int row,
                                                    input logic signed [31:0] x,
                                                    input logic signed [31:0] y,
                                                    input logic signed [31:0] z);
        logic signed [95:0] acc;
        begin
            acc = coef_shadow[row*4] * x + coef_shadow[row*4+1] * y
                + coef_shadow[row*4+2] * z;
            clip_row = (acc >>> FRAC_BITS) + coef_shadow[row*4+3];
        end
    endfunction

    // Map one clip component to a saturated pixel coordinate
    function automatic logic signed [31:0] pixel_coord(input logic signed [95:0] c,
                                                       input logic signed [95:0] w,
                                                       input logic [SIZE_W-1:0] size,
                                                       input logic invert);
        logic [127:0]        mag;
        logic [127:0]        quot;
        logic signed [127:0] v;
        logic                neg;
        begin
            neg  = c < 0;
            mag  = neg ? 128'(-c) : 128'(c);
            quot = ((mag * size) << FRAC_BITS) / (128'(w) * 2);
            v    = $signed(quot);
            if (neg != invert)
                v = -v;
            v = v + $signed(128'(size) << (FRAC_BITS - 1));
            if (v > 128'sh7FFFFFFF)
                v = 128'sh7FFFFFFF;
            if (v < -128'sh80000000)
                v = -128'sh80000000;
            pixel_coord = v[31:0];
        end
    endfunction

    // Apply an accepted load to the shadow state, or queue the pixel of an accepted projection
    task automatic predict_point(input point_cmd_t c);
        logic signed [95:0] cx, cy, cw;
        pixel_t px;
        begin
            if (c.operation == OP_LOAD)
            begin
                coef_shadow[c.coef_index] = c.coef_value;
                loads_done++;
            end
            else
            begin
                cx = clip_row(0, c.pos_x, c.pos_y, c.pos_z);
                cy = clip_row(1, c.pos_x, c.pos_y, c.pos_z);
                cw = clip_row(3, c.pos_x, c.pos_y, c.pos_z);
                if (cw < 0 || cw * 10 < VIS_MIN)
                begin
                    px.visible  = 1'b0;
                    px.screen_x = '0;
                    px.screen_y = '0;
                end
                else
                begin
                    px.visible  = 1'b1;
                    px.screen_x = pixel_coord(cx, cw, width_shadow, 1'b0);
                    px.screen_y = pixel_coord(cy, cw, height_shadow, 1'b1);
                end
                pixel_queue.push_back(px);
                projects_done++;
            end
        end
    endtask

    // Driver: bursts of transactions with random gaps
    initial
    begin
        in_ch.valid      = 1'b0;
        in_ch.operation  = OP_LOAD;
        in_ch.coef_index = '0;
        in_ch.coef_value = '0;
        in_ch.pos_x      = '0;
        in_ch.pos_y      = '0;
        in_ch.pos_z      = '0;
        burst_left       = 1;
        gap_left         = 0;
    end

    always @(posedge clk)
    begin
        point_cmd_t acc_cmd;
        point_cmd_t nxt;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                acc_cmd.operation  = in_ch.operation;
                acc_cmd.coef_index = in_ch.coef_index;
                acc_cmd.coef_value = in_ch.coef_value;
                acc_cmd.pos_x      = in_ch.pos_x;
                acc_cmd.pos_y      = in_ch.pos_y;
                acc_cmd.pos_z      = in_ch.pos_z;
                predict_point(acc_cmd);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left > 0 || cmd_queue.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else
                begin
                    nxt = cmd_queue.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.operation  <= nxt.operation;
                    in_ch.coef_index <= nxt.coef_index;
                    in_ch.coef_value <= nxt.coef_value;
                    in_ch.pos_x      <= nxt.pos_x;
                    in_ch.pos_y      <= nxt.pos_y;
                    in_ch.pos_z      <= nxt.pos_z;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Monitor: stall on a changing duty and check each result transaction
    always @(posedge clk)
    begin
        pixel_t exp_px;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_pct   = 0;
            stall_timer = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pixel_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result vis=%0b x=%h y=%h", $time,
                             out_ch.visible, out_ch.screen_x, out_ch.screen_y);
                end
                else
                begin
                    exp_px = pixel_queue.pop_front();
                    pixels_checked++;
                    if (exp_px.visible)
                        visible_checked++;
                    if (out_ch.visible !== exp_px.visible)
                    begin
                        errors++;
                        $display("%0t: visible expected %0b actual %0b", $time,
                                 exp_px.visible, out_ch.visible);
                    end
                    if (out_ch.screen_x !== exp_px.screen_x)
                    begin
                        errors++;
                        $display("%0t: screen_x expected %h actual %h", $time,
                                 exp_px.screen_x, out_ch.screen_x);
                    end
                    if (out_ch.screen_y !== exp_px.screen_y)
                    begin
                        errors++;
                        $display("%0t: screen_y expected %h actual %h", $time,
                                 exp_px.screen_y, out_ch.screen_y);
                    end
                end
            end
            stall_timer++;
            if (stall_timer >= 150)
            begin
                stall_timer = 0;
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic point_cmd_t load_cmd(input int idx, input logic signed [31:0] val);
        point_cmd_t c;
        begin
            c = '{OP_LOAD, 4'(idx), val, $urandom, $urandom, $urandom};
            load_cmd = c;
        end
    endfunction

    function automatic point_cmd_t project_cmd(input logic signed [31:0] x,
                                               input logic signed [31:0] y,
                                               input logic signed [31:0] z);
        point_cmd_t c;
        begin
            c = '{OP_PROJECT, 4'($urandom), $urandom, x, y, z};
            project_cmd = c;
        end
    endfunction

    // Random value: mostly moderate, sometimes any 32-bit pattern
    function automatic logic signed [31:0] rand_fixed(input int span);
        begin
            if ($urandom_range(0, 9) == 0)
                rand_fixed = $urandom;
            else
                rand_fixed = $signed($urandom_range(0, 2 * span)) - span;
        end
    endfunction

    task automatic write_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= REG_SCREEN_WIDTH;
            cfg_data  <= w;
            width_shadow = w;
            @(posedge clk);
            cfg_index <= REG_SCREEN_HEIGHT;
            cfg_data  <= h;
            height_shadow = h;
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // Hold until every queued transaction has gone in and every result came back
    task automatic drain;
        begin
            while (cmd_queue.size() != 0 || in_ch.valid || pixel_queue.size() != 0)
                @(posedge clk);
            repeat (60) @(posedge clk);
        end
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        begin
            case ($urandom_range(0, 4))
                0: pick_size = 13'd1;
                1: pick_size = 13'd4096;
                2: pick_size = 13'h1FFF;
                3: pick_size = 13'd0;
                default: pick_size = SIZE_W'($urandom_range(1, 4096));
            endcase
        end
    endfunction

    // Stimulus
    initial
    begin
        logic [SIZE_W-1:0] w, h;
        int op_sel;
        errors = 0;
        loads_done = 0;
        projects_done = 0;
        pixels_checked = 0;
        visible_checked = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_SCREEN_WIDTH;
        cfg_data  = '0;
        foreach (coef_shadow[i])
            coef_shadow[i] = '0;
        width_shadow  = WIDTH_RESET;
        height_shadow = HEIGHT_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: cleared matrix gives w of zero, then a simple camera
        cmd_queue.push_back(project_cmd(32'sh00010000, 32'sh00020000, 32'sh00030000));
        cmd_queue.push_back(load_cmd(0, 32'sh00010000));
        cmd_queue.push_back(load_cmd(5, 32'sh00010000));
        cmd_queue.push_back(load_cmd(15, 32'sh00010000));
        cmd_queue.push_back(project_cmd(0, 0, 0));
        cmd_queue.push_back(project_cmd(32'sh00008000, -32'sh00008000, 0));
        cmd_queue.push_back(project_cmd(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
        cmd_queue.push_back(project_cmd(32'sh80000000, 32'sh80000000, 32'sh80000000));
        // Visibility threshold just below and just above 0.1
        cmd_queue.push_back(load_cmd(15, 32'sd6553));
        cmd_queue.push_back(project_cmd(32'sh00010000, 32'sh00010000, 0));
        cmd_queue.push_back(load_cmd(15, 32'sd6554));
        cmd_queue.push_back(project_cmd(32'sh00010000, 32'sh00010000, 0));
        cmd_queue.push_back(project_cmd(32'sh80000000, 32'sh7FFFFFFF, 0));
        // Negative w, then extreme coefficients in the w row and the x row
        cmd_queue.push_back(load_cmd(15, 32'sh80000000));
        cmd_queue.push_back(project_cmd(0, 0, 0));
        cmd_queue.push_back(load_cmd(15, 32'sh7FFFFFFF));
        cmd_queue.push_back(load_cmd(14, 32'sh7FFFFFFF));
        cmd_queue.push_back(load_cmd(1, 32'sh80000000));
        cmd_queue.push_back(project_cmd(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000));
        cmd_queue.push_back(project_cmd(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
        drain();

        // Random phases, each with its own screen size and a fresh camera
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
            begin
                w = 13'd1;
                h = 13'h1FFF;
            end
            else if (phase == 1)
            begin
                w = 13'd4096;
                h = 13'd0;
            end
            else
            begin
                w = pick_size();
                h = pick_size();
            end
            write_screen(w, h);
            for (int i = 0; i < 16; i++)
            begin
                if (i >= 12 && i < 15)
                    cmd_queue.push_back(load_cmd(i, rand_fixed(32'sd1500)));
                else if (i == 15)
                    cmd_queue.push_back(load_cmd(i, $urandom_range(32'h1000, 32'hA0000)));
                else
                    cmd_queue.push_back(load_cmd(i, rand_fixed(32'sh40000)));
            end
            for (int i = 0; i < 150; i++)
            begin
                op_sel = $urandom_range(0, 9);
                if (op_sel == 0)
                    cmd_queue.push_back(load_cmd($urandom_range(0, 15), rand_fixed(32'sh40000)));
                else
                    cmd_queue.push_back(project_cmd(rand_fixed(32'sh4000000),
                                                    rand_fixed(32'sh4000000),
                                                    rand_fixed(32'sh4000000)));
            end
            drain();
        end

        $display("Run covered %0d loads and %0d projections over 9 screen settings.",
                 loads_done, projects_done);
        $display("Checked %0d results, %0d of them visible.", pixels_checked, visible_checked);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Timeout
    initial
    begin
        #20ms;
        $display("Timeout with %0d results outstanding.", pixel_queue.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

// File: world_to_screen_projection.f
+incdir+src
src/wsp_pkg.sv
src/wsp_if.sv
src/wsp_clip.sv
src/wsp_prep.sv
src/wsp_div.sv
src/world_to_screen_projection.sv
src/wsp_checker.sv
tb/sv/world_to_screen_projection_test.sv
